[design/wbi_pkg.sv]
// Shared types, constants and the arctangent table for the wind interpolator.
// No dependencies.
package wbi_pkg;

  localparam int unsigned CorWidth = 28;           // signed CORDIC x/y width
  localparam int unsigned AngWidth = 30;           // signed angle width, degrees Q16
  localparam int unsigned SpdWidth = 24;           // corner speed, 1/65536 m/s
  localparam int unsigned DirWidth = 25;           // corner direction, degrees Q16
  localparam logic [19:0] InvGain = 20'd636751;    // 1/K in Q20
  localparam logic signed [AngWidth-1:0] Deg180 = 30'sd11796480;
  localparam logic signed [AngWidth-1:0] DegM90 = -30'sd5898240;
  localparam logic signed [AngWidth-1:0] Deg360 = 30'sd23592960;
  localparam logic [20:0] LonLimit = 21'd1474560;
  localparam logic signed [19:0] LatLimit = 20'sd368640;
  localparam logic [15:0] SpdMax = 16'd46341;
  localparam logic [14:0] DirMax = 15'd23039;

  localparam logic CfgLon = 1'b0;
  localparam logic CfgLat = 1'b1;

  typedef struct packed {
    logic signed [15:0] nw_u;
    logic signed [15:0] nw_v;
    logic signed [15:0] ne_u;
    logic signed [15:0] ne_v;
    logic signed [15:0] se_u;
    logic signed [15:0] se_v;
    logic signed [15:0] sw_u;
    logic signed [15:0] sw_v;
  } in_item_t;

  typedef struct packed {
    logic [15:0] wind_speed;
    logic [14:0] wind_direction;
    logic        position_valid;
  } out_item_t;

  // atan(2^-i) in degrees Q16
  function automatic logic signed [AngWidth-1:0] atan_q16(input logic [4:0] i);
    logic signed [AngWidth-1:0] a;
    case (i)
      5'd0: a = 30'sd2949120;   5'd1: a = 30'sd1740967;
      5'd2: a = 30'sd919879;    5'd3: a = 30'sd466945;
      5'd4: a = 30'sd234379;    5'd5: a = 30'sd117304;
      5'd6: a = 30'sd58666;     5'd7: a = 30'sd29335;
      5'd8: a = 30'sd14668;     5'd9: a = 30'sd7334;
      5'd10: a = 30'sd3667;     5'd11: a = 30'sd1833;
      5'd12: a = 30'sd917;      5'd13: a = 30'sd458;
      5'd14: a = 30'sd229;      5'd15: a = 30'sd115;
      5'd16: a = 30'sd57;       5'd17: a = 30'sd29;
      5'd18: a = 30'sd14;       5'd19: a = 30'sd7;
      5'd20: a = 30'sd4;        5'd21: a = 30'sd2;
      5'd22: a = 30'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[design/wbi_stream_if.sv]
// Valid/ready stream interface carrying one payload type.
// No package dependency; the payload type is given by parameter.
interface wbi_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/wbi_corner.sv]
// Pipelined vectoring CORDIC for one grid corner: speed and direction.
// Depends on wbi_pkg. Every register advances only on en.
module wbi_corner #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [15:0]             u,
  input  logic signed [15:0]             v,
  output logic [wbi_pkg::SpdWidth-1:0]   speed,
  output logic [wbi_pkg::DirWidth-1:0]   direction
);
  localparam int unsigned CW = wbi_pkg::CorWidth;
  localparam int unsigned AW = wbi_pkg::AngWidth;

  logic signed [CW-1:0] x_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_r [CORDIC_STAGES+1];
  logic signed [AW-1:0] z_r [CORDIC_STAGES+1];
  logic                 calm_r [CORDIC_STAGES+1];

  // prerotation into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      calm_r[0] <= (u == 16'sd0) && (v == 16'sd0);
      if (u < 0) begin
        x_r[0] <= -({{(CW-16){u[15]}}, u} <<< 8);
        y_r[0] <= -({{(CW-16){v[15]}}, v} <<< 8);
        z_r[0] <= (v >= 0) ? wbi_pkg::Deg180 : -wbi_pkg::Deg180;
      end else begin
        x_r[0] <= {{(CW-16){u[15]}}, u} <<< 8;
        y_r[0] <= {{(CW-16){v[15]}}, v} <<< 8;
        z_r[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        calm_r[i+1] <= calm_r[i];
        if (!y_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + wbi_pkg::atan_q16(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - wbi_pkg::atan_q16(5'(i));
        end
      end
    end
  end

  // gain correction and direction conversion
  logic [CW-2:0]        mag;
  logic signed [AW-1:0] zf, d0, d1;
  logic [CW-2:0]        mag_r;
  logic [wbi_pkg::DirWidth-1:0] dir_r, dir2_r;
  logic [CW+19:0]       prod_r;

  always_comb begin
    mag = x_r[CORDIC_STAGES][CW-1] ? '0 : x_r[CORDIC_STAGES][CW-2:0];
    if (calm_r[CORDIC_STAGES]) mag = '0;
    zf  = calm_r[CORDIC_STAGES] ? '0 : z_r[CORDIC_STAGES];
    d0  = wbi_pkg::DegM90 - zf;
    d1  = d0[AW-1] ? d0 + wbi_pkg::Deg360 : d0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag;
      if (d1[AW-1]) dir_r <= '0;
      else if (d1 >= wbi_pkg::Deg360) dir_r <= 25'(wbi_pkg::Deg360 - 1);
      else dir_r <= d1[wbi_pkg::DirWidth-1:0];
      prod_r <= {{20{1'b0}}, mag_r} * {{(CW-1){1'b0}}, wbi_pkg::InvGain};
      dir2_r <= dir_r;
    end
  end

  assign speed     = prod_r[wbi_pkg::SpdWidth+19:20];
  assign direction = dir2_r;
endmodule

[design/wind_bilinear_interpolator_core.sv]
// Top level of the wind interpolator: four corner CORDICs and a blend pipeline.
// Depends on wbi_pkg, wbi_stream_if and wbi_corner.
//
// Usage: the input channel carries the u/v components of four cell corners;
// the result channel returns interpolated speed (1/256 m/s), direction
// (1/64 degree) and position_valid. The query position sits in two config
// registers (index 0 longitude, index 1 latitude), written while idle.
// Throughput: one item per cycle while not stalled; the whole datapath is a
// single pipeline of CORDIC_STAGES + 8 stages that advances whenever its
// last stage is empty or the receiver takes the result. Each CORDIC stage
// is one rotation; the blend multiplies in stages A and C and adds in
// stages B and D.
// A stall freezes the whole pipeline with no loss; in_ready falls only
// while the output holds a result the receiver has not taken.
// Reset clears all valid bits and sets both position registers to zero.
module wind_bilinear_interpolator_core #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned CELL_FRACTION_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  wbi_stream_if.sink         in_ch,
  wbi_stream_if.source       out_ch,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [20:0]        cfg_data
);
  localparam int unsigned FB    = CELL_FRACTION_BITS;
  localparam int unsigned DEPTH = CORDIC_STAGES + 8;
  localparam int unsigned SW    = wbi_pkg::SpdWidth;
  localparam int unsigned DW    = wbi_pkg::DirWidth;
  localparam int unsigned RW    = 2 * FB + DW + 3;

  // configuration registers
  logic [20:0]        lon_r;
  logic signed [19:0] lat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_r <= '0;
      lat_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == wbi_pkg::CfgLon) lon_r <= cfg_data;
      else lat_r <= cfg_data[19:0];
    end
  end

  // cell weights: 10-bit floor fraction rescaled to FB bits
  logic pos_ok;
  logic [FB:0] fx, fy;
  assign pos_ok = (lon_r < wbi_pkg::LonLimit) && (lat_r >= -wbi_pkg::LatLimit)
                  && (lat_r <= wbi_pkg::LatLimit);
  assign fx = (FB+1)'({lon_r[9:0], 16'b0} >> (26 - FB));
  assign fy = (FB+1)'({lat_r[9:0], 16'b0} >> (26 - FB));

  // pipeline valid bits and stall control
  logic [DEPTH-1:0] vld_r;
  logic en;
  assign en = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
  end

  // corner CORDICs: nw, ne, se, sw
  logic [SW-1:0] spd [4];
  logic [DW-1:0] dir [4];
  wbi_corner #(.CORDIC_STAGES(CORDIC_STAGES)) u_nw (.clk, .en,
    .u(in_ch.data.nw_u), .v(in_ch.data.nw_v), .speed(spd[0]), .direction(dir[0]));
  wbi_corner #(.CORDIC_STAGES(CORDIC_STAGES)) u_ne (.clk, .en,
    .u(in_ch.data.ne_u), .v(in_ch.data.ne_v), .speed(spd[1]), .direction(dir[1]));
  wbi_corner #(.CORDIC_STAGES(CORDIC_STAGES)) u_se (.clk, .en,
    .u(in_ch.data.se_u), .v(in_ch.data.se_v), .speed(spd[2]), .direction(dir[2]));
  wbi_corner #(.CORDIC_STAGES(CORDIC_STAGES)) u_sw (.clk, .en,
    .u(in_ch.data.sw_u), .v(in_ch.data.sw_v), .speed(spd[3]), .direction(dir[3]));

  // blend stage A: x weights (corner values are unsigned, fit in 25 bits)
  logic [DW+FB:0] sn_r [4];   // sw*(1-fx), se*fx, nw*(1-fx), ne*fx
  logic [FB:0] omx, omy;
  assign omx = (FB+1)'(1 << FB) - fx;
  assign omy = (FB+1)'(1 << FB) - fy;
  logic [DW+FB:0] ds_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      sn_r[0] <= (DW+FB+1)'(spd[3] * omx);
      sn_r[1] <= (DW+FB+1)'(spd[2] * fx);
      sn_r[2] <= (DW+FB+1)'(spd[0] * omx);
      sn_r[3] <= (DW+FB+1)'(spd[1] * fx);
      ds_r[0] <= (DW+FB+1)'(dir[3] * omx);
      ds_r[1] <= (DW+FB+1)'(dir[2] * fx);
      ds_r[2] <= (DW+FB+1)'(dir[0] * omx);
      ds_r[3] <= (DW+FB+1)'(dir[1] * fx);
    end
  end

  // stage B: row sums
  logic [DW+FB+1:0] ss_r, sn2_r, ds2_r, dn2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ss_r  <= (DW+FB+2)'(sn_r[0]) + (DW+FB+2)'(sn_r[1]);
      sn2_r <= (DW+FB+2)'(sn_r[2]) + (DW+FB+2)'(sn_r[3]);
      ds2_r <= (DW+FB+2)'(ds_r[0]) + (DW+FB+2)'(ds_r[1]);
      dn2_r <= (DW+FB+2)'(ds_r[2]) + (DW+FB+2)'(ds_r[3]);
    end
  end

  // stage C: y weights
  logic [RW-1:0] sa_r, sb_r, da_r, db_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sa_r <= RW'(ss_r * omy);
      sb_r <= RW'(sn2_r * fy);
      da_r <= RW'(ds2_r * omy);
      db_r <= RW'(dn2_r * fy);
    end
  end

  // stage D: final sums with rounding
  logic [RW-1:0] sacc_r, dacc_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sacc_r <= sa_r + sb_r + (RW'(1) << (2*FB+7));
      dacc_r <= da_r + db_r + (RW'(1) << (2*FB+9));
    end
  end

  // stage E: shift, saturate and gate by position
  logic [RW-1:0] s_sh, d_sh;
  assign s_sh = sacc_r >> (2*FB+8);
  assign d_sh = dacc_r >> (2*FB+10);
  wbi_pkg::out_item_t res_r;
  always_ff @(posedge clk) begin
    if (en) begin
      res_r.position_valid <= pos_ok;
      res_r.wind_speed <= !pos_ok ? '0 :
        (s_sh > RW'(wbi_pkg::SpdMax)) ? wbi_pkg::SpdMax : s_sh[15:0];
      res_r.wind_direction <= !pos_ok ? '0 :
        (d_sh > RW'(wbi_pkg::DirMax)) ? wbi_pkg::DirMax : d_sh[14:0];
    end
  end

  assign out_ch.valid = vld_r[DEPTH-1];
  assign out_ch.data  = res_r;

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(vld_r))
    else $error("pipeline moved during stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.position_valid |->
      out_ch.data.wind_speed == '0 && out_ch.data.wind_direction == '0)
    else $error("invalid position gave nonzero result");
`endif
endmodule
